// ===== sv/lhm_pkg.sv =====
// Shared types, field widths, operation codes and helper functions for the latency histogram monitor.
package lhm_pkg;

    localparam int TIME_W = 64;
    localparam int SEQ_W  = 32;
    localparam int FRAC_W = 17;
    localparam int HIST_W = 32;
    localparam int OP_W   = 2;

    // Stream widths: input tdata is padded to whole bytes.
    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 704;

    // Rounding bias added before the rank is scaled down by 2^16.
    localparam logic [15:0] ROUND_UP_BIAS = 16'd65470;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;
    localparam logic [OP_W-1:0] OP_PCTL   = 2'd3;

    typedef logic [TIME_W-1:0] time_t;

    // Packed so that the first member lands in the highest bits of tdata.
    typedef struct packed {
        time_t software_max_ns;
        time_t software_sum_ns;
        time_t software_count;
        time_t latency_sum_us;
        time_t latency_max_us;
        time_t latency_min_us;
        time_t latency_count;
        time_t signal_total;
        time_t percentile_us;
        time_t feed_age_us;
        time_t latency_us;
    } result_t;

    // Index of the highest set bit; zero for inputs of zero or one.
    // Six halving steps, each testing the upper part of what is left.
    function automatic logic [5:0] lhm_msb(input time_t value);
        logic [5:0] pos;
        time_t      rest;
        int         k;
        pos  = '0;
        rest = value;
        for (k = 5; k >= 0; k--)
        begin
            if ((rest >> (1 << k)) != '0)
            begin
                pos[k] = 1'b1;
                rest   = rest >> (1 << k);
            end
        end
        return pos;
    endfunction

endpackage

// ===== sv/lhm_ring.sv =====
// Tick time ring: sequence-to-slot reduction pipeline, storage memory and clearing sweep.
module lhm_ring
    import lhm_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             write,
    input  logic [SEQ_W-1:0] seq,
    input  time_t            wdata,
    output logic             busy,
    output logic             done,
    output time_t            rdata
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int PROD_W = 65;
    localparam int Q_W    = PROD_W - SEQ_W - SLOT_W;
    // Reciprocal of the depth, rounded down; the quotient estimate is short by at most one.
    localparam logic [32:0] RECIP = 33'((65'd1 << (SEQ_W + SLOT_W)) / RING_DEPTH);
    localparam logic [SLOT_W:0] DEPTH_V = (SLOT_W + 1)'(RING_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

    logic [PROD_W-1:0] prod_reg;
    logic [SEQ_W-1:0]  seq_a_reg;
    logic              va_reg;
    logic              wr_a_reg;
    logic [SLOT_W:0]   r0_reg;
    logic              vb_reg;
    logic              wr_b_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  clr_cnt_reg;
    time_t             rdata_reg;

    logic [PROD_W-1:0] prod_next;
    logic [Q_W-1:0]    quot;
    logic [63:0]       qd_full;
    logic [SEQ_W-1:0]  r0_full;
    logic [SLOT_W:0]   slot_full;
    logic [SLOT_W-1:0] slot;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_addr;
    time_t             mem_wdata;

    time_t ring_mem [RING_DEPTH];

    assign busy = (clr_cnt_reg != DEPTH_CNT);

    always_comb
    begin
        prod_next = {33'd0, seq} * {32'd0, RECIP};
        quot      = prod_reg[PROD_W-1 -: Q_W];
        qd_full   = {{(64 - Q_W){1'b0}}, quot} * 64'(RING_DEPTH);
        r0_full   = seq_a_reg - qd_full[SEQ_W-1:0];
        slot_full = (r0_reg >= DEPTH_V) ? (r0_reg - DEPTH_V) : r0_reg;
        slot      = slot_full[SLOT_W-1:0];
        mem_we    = busy || (vb_reg && wr_b_reg);
        mem_addr  = busy ? clr_cnt_reg[SLOT_W-1:0] : slot;
        mem_wdata = busy ? '0 : wdata;
    end

    // Stage A multiplies by the reciprocal, stage B forms the remainder, stage C corrects it
    // and touches the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg      <= 1'b0;
            wr_a_reg    <= 1'b0;
            vb_reg      <= 1'b0;
            wr_b_reg    <= 1'b0;
            done_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            prod_reg    <= '0;
            seq_a_reg   <= '0;
            r0_reg      <= '0;
        end
        else
        begin
            va_reg   <= start;
            wr_a_reg <= write;
            vb_reg   <= va_reg;
            wr_b_reg <= wr_a_reg;
            done_reg <= vb_reg;
            if (start)
            begin
                prod_reg  <= prod_next;
                seq_a_reg <= seq;
            end
            if (va_reg)
            begin
                r0_reg <= r0_full[SLOT_W:0];
            end
            if (busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        if (vb_reg && !wr_b_reg)
        begin
            rdata_reg <= ring_mem[slot];
        end
    end

    assign done  = done_reg;
    assign rdata = rdata_reg;

endmodule

// ===== sv/lhm_hist.sv =====
// Bucket count memory with registered read, saturating increment write-back and clearing sweep.
module lhm_hist
    import lhm_pkg::*;
#(
    parameter int BUCKETS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(BUCKETS)-1:0] rd_addr,
    input  logic                       inc_en,
    output logic                       busy,
    output logic [HIST_W-1:0]          rd_data
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int CNT_W = $clog2(BUCKETS + 1);
    localparam logic [CNT_W-1:0] BUCKETS_CNT = CNT_W'(BUCKETS);

    logic [CNT_W-1:0]  clr_cnt_reg;
    logic [BKT_W-1:0]  addr_hold_reg;
    logic [HIST_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [BKT_W-1:0]  mem_addr;
    logic [HIST_W-1:0] mem_wdata;

    logic [HIST_W-1:0] hist_mem [BUCKETS];

    assign busy = (clr_cnt_reg != BUCKETS_CNT);

    // An increment writes back the count read in the previous cycle, held at all ones.
    always_comb
    begin
        mem_we   = busy || inc_en;
        mem_addr = busy ? clr_cnt_reg[BKT_W-1:0] : addr_hold_reg;
        if (busy)
        begin
            mem_wdata = '0;
        end
        else if (rd_data_reg == '1)
        begin
            mem_wdata = rd_data_reg;
        end
        else
        begin
            mem_wdata = rd_data_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (busy)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg   <= hist_mem[rd_addr];
            addr_hold_reg <= rd_addr;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lhm_rank.sv =====
// Percentile target rank unit: split multiply, rounding add and clamp, each in its own register stage.
module lhm_rank
    import lhm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  time_t             count,
    input  logic [FRAC_W-1:0] fraction,
    output logic              done,
    output time_t             want
);

    localparam int PART_W = 32 + FRAC_W;
    localparam int FULL_W = TIME_W + FRAC_W;

    logic [PART_W-1:0] low_reg;
    logic [PART_W-1:0] mid_reg;
    logic [TIME_W:0]   rank_reg;
    time_t             want_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              done_reg;

    logic [FULL_W-1:0] prod_full;
    time_t             rank_sat;
    time_t             want_next;

    // The count must hold still from start until done.
    always_comb
    begin
        prod_full = {{(FULL_W - PART_W){1'b0}}, low_reg}
                  + {mid_reg, 32'd0}
                  + FULL_W'(ROUND_UP_BIAS);
        rank_sat  = rank_reg[TIME_W] ? '1 : rank_reg[TIME_W-1:0];
        if (rank_sat == '0)
        begin
            want_next = time_t'(1);
        end
        else if (rank_sat > count)
        begin
            want_next = count;
        end
        else
        begin
            want_next = rank_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            low_reg  <= '0;
            mid_reg  <= '0;
            rank_reg <= '0;
            want_reg <= '0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            if (start)
            begin
                low_reg <= {{FRAC_W{1'b0}}, count[31:0]} * {32'd0, fraction};
                mid_reg <= {{FRAC_W{1'b0}}, count[63:32]} * {32'd0, fraction};
            end
            if (v1_reg)
            begin
                rank_reg <= prod_full[FULL_W-1:16];
            end
            if (v2_reg)
            begin
                want_reg <= want_next;
            end
        end
    end

    assign done = done_reg;
    assign want = want_reg;

endmodule

// ===== sv/latency_histogram_monitor.sv =====
// Top level of the latency histogram monitor: event sequencer, statistics registers and result stage.
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   tuser: opcode; tdata: sequence, time, sample, fraction
//  m_*      out        m_tvalid/m_tready   tuser: latency_valid; tdata: latency and 10 statistics
//
// One event is worked on at a time. A software sample goes straight to the result stage; a tick
// and a signal wait on the three-stage slot reduction in front of the ring memory. A percentile
// query runs the rank unit, then one read and one check per bucket on the single histogram port.
// After reset the block clears the ring and the histogram, one entry a cycle, and takes no event
// until both are cleared. A new event is taken while the previous result still waits in the
// output register; its result is then held back until that register is free.
module latency_histogram_monitor
    import lhm_pkg::*;
#(
    parameter int BUCKETS    = 32,
    parameter int RING_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata, lowest bit first: sequence_req[31:0], now_us[95:32], sample_ns[159:96],
    // fraction[176:160], zero pad[183:177].
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, lowest bit first: latency_us, feed_age_us, percentile_us, signal_total,
    // latency_count, latency_min_us, latency_max_us, latency_sum_us, software_count,
    // software_sum_ns, software_max_ns, 64 bits each.
    output logic [M_DATA_W-1:0] m_tdata,
    // m_tuser: latency_valid[0].
    output logic [0:0]          m_tuser
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SEEN_W = HIST_W + BKT_W;
    localparam logic [5:0] LAST_BKT = 6'(BUCKETS - 1);
    localparam logic [BKT_W-1:0] LAST_IDX = BKT_W'(BUCKETS - 1);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_RING     = 4'd2;
    localparam logic [3:0] ST_SIG_REC  = 4'd3;
    localparam logic [3:0] ST_SIG_INC  = 4'd4;
    localparam logic [3:0] ST_RANK     = 4'd5;
    localparam logic [3:0] ST_WALK_RD  = 4'd6;
    localparam logic [3:0] ST_WALK_CHK = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;

    logic [OP_W-1:0]   op_reg;
    time_t             now_reg;
    time_t             last_tick_reg;
    time_t             sig_cnt_reg;
    time_t             rec_cnt_reg;
    time_t             rec_sum_reg;
    time_t             rec_min_reg;
    time_t             rec_max_reg;
    time_t             soft_cnt_reg;
    time_t             soft_sum_reg;
    time_t             soft_max_reg;
    time_t             lat_reg;
    logic              lat_ok_reg;
    time_t             pct_reg;
    time_t             want_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [BKT_W-1:0]  walk_reg;
    result_t           res_reg;
    logic              valid_out_reg;
    logic              m_tvalid_reg;

    logic [OP_W-1:0]   in_op;
    logic [SEQ_W-1:0]  in_seq;
    time_t             in_now;
    time_t             in_sample;
    logic [FRAC_W-1:0] in_frac;
    logic              accept;
    logic              out_free;

    logic              ring_start;
    logic              ring_busy;
    logic              ring_done;
    time_t             ring_rdata;
    logic              hist_rd_en;
    logic [BKT_W-1:0]  hist_rd_addr;
    logic              hist_inc;
    logic              hist_busy;
    logic [HIST_W-1:0] hist_rd_data;
    logic              rank_start;
    logic              rank_done;
    time_t             rank_want;

    logic [5:0]        lat_msb;
    logic [5:0]        lat_bkt;
    logic [SEEN_W-1:0] seen_next;
    logic [6:0]        edge_pos;
    time_t             edge_val;
    time_t             feed_age;

    assign in_op     = s_tuser;
    assign in_seq    = s_tdata[31:0];
    assign in_now    = s_tdata[95:32];
    assign in_sample = s_tdata[159:96];
    assign in_frac   = s_tdata[176:160];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ring_start = accept && ((in_op == OP_TICK) || (in_op == OP_SIGNAL));
    assign rank_start = (state_reg == ST_IDLE) && accept && (in_op == OP_PCTL)
                        && (rec_cnt_reg != '0);

    lhm_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ring_start),
        .write (in_op == OP_TICK),
        .seq   (in_seq),
        .wdata (now_reg),
        .busy  (ring_busy),
        .done  (ring_done),
        .rdata (ring_rdata)
    );

    lhm_hist #(
        .BUCKETS (BUCKETS)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .inc_en  (hist_inc),
        .busy    (hist_busy),
        .rd_data (hist_rd_data)
    );

    // The rank unit samples the fraction of the query in the cycle of its transfer.
    lhm_rank u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rank_start),
        .count    (rec_cnt_reg),
        .fraction (in_frac),
        .done     (rank_done),
        .want     (rank_want)
    );

    // Bucket of the latency: log2 floor, with zero and one in the first bucket and
    // everything large in the last.
    always_comb
    begin
        lat_msb      = lhm_msb(lat_reg);
        lat_bkt      = (lat_msb > LAST_BKT) ? LAST_BKT : lat_msb;
        hist_rd_en   = (state_reg == ST_SIG_REC) || (state_reg == ST_WALK_RD);
        hist_rd_addr = (state_reg == ST_SIG_REC) ? lat_bkt[BKT_W-1:0] : walk_reg;
        hist_inc     = (state_reg == ST_SIG_INC) && lat_ok_reg;
    end

    // Walk step: running rank and the upper edge of the current bucket.
    always_comb
    begin
        seen_next = seen_reg + SEEN_W'(hist_rd_data);
        edge_pos  = 7'(walk_reg) + 7'd1;
        edge_val  = edge_pos[6] ? '1 : (time_t'(1) << edge_pos[5:0]);
        feed_age  = (now_reg > last_tick_reg) ? (now_reg - last_tick_reg) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!ring_busy && !hist_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_TICK:   state_next = ST_RING;
                        OP_SIGNAL: state_next = ST_RING;
                        OP_SAMPLE: state_next = ST_DONE;
                        OP_PCTL:   state_next = (rec_cnt_reg != '0) ? ST_RANK : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_RING:
            begin
                if (ring_done)
                begin
                    state_next = (op_reg == OP_SIGNAL) ? ST_SIG_REC : ST_DONE;
                end
            end
            ST_SIG_REC:  state_next = ST_SIG_INC;
            ST_SIG_INC:  state_next = ST_DONE;
            ST_RANK:
            begin
                if (rank_done)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:  state_next = ST_WALK_CHK;
            ST_WALK_CHK:
            begin
                if ((64'(seen_next) >= want_reg) || (walk_reg == LAST_IDX))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_TICK;
            now_reg       <= '0;
            last_tick_reg <= '0;
            sig_cnt_reg   <= '0;
            rec_cnt_reg   <= '0;
            rec_sum_reg   <= '0;
            rec_min_reg   <= '1;
            rec_max_reg   <= '0;
            soft_cnt_reg  <= '0;
            soft_sum_reg  <= '0;
            soft_max_reg  <= '0;
            lat_reg       <= '0;
            lat_ok_reg    <= 1'b0;
            pct_reg       <= '0;
            want_reg      <= '0;
            seen_reg      <= '0;
            walk_reg      <= '0;
            res_reg       <= '0;
            valid_out_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A new result loads the output register as soon as it is free.
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= in_op;
                        now_reg    <= in_now;
                        lat_reg    <= '0;
                        lat_ok_reg <= 1'b0;
                        pct_reg    <= '0;
                        case (in_op)
                            OP_TICK:
                            begin
                                last_tick_reg <= in_now;
                            end
                            OP_SIGNAL:
                            begin
                                sig_cnt_reg <= sig_cnt_reg + 1'b1;
                            end
                            OP_SAMPLE:
                            begin
                                soft_cnt_reg <= soft_cnt_reg + 1'b1;
                                soft_sum_reg <= soft_sum_reg + in_sample;
                                if (in_sample > soft_max_reg)
                                begin
                                    soft_max_reg <= in_sample;
                                end
                            end
                            default:
                            begin
                                // A query on an empty histogram answers zero at once.
                            end
                        endcase
                    end
                end
                ST_RING:
                begin
                    // A zero slot means no tick was stored; a tick later than now is ignored.
                    if (ring_done && (op_reg == OP_SIGNAL))
                    begin
                        lat_reg    <= now_reg - ring_rdata;
                        lat_ok_reg <= (ring_rdata != '0) && (now_reg >= ring_rdata);
                    end
                end
                ST_SIG_REC:
                begin
                    if (lat_ok_reg)
                    begin
                        rec_cnt_reg <= rec_cnt_reg + 1'b1;
                        rec_sum_reg <= rec_sum_reg + lat_reg;
                        if (lat_reg < rec_min_reg)
                        begin
                            rec_min_reg <= lat_reg;
                        end
                        if (lat_reg > rec_max_reg)
                        begin
                            rec_max_reg <= lat_reg;
                        end
                    end
                end
                ST_RANK:
                begin
                    if (rank_done)
                    begin
                        want_reg <= rank_want;
                        seen_reg <= '0;
                        walk_reg <= '0;
                    end
                end
                ST_WALK_CHK:
                begin
                    seen_reg <= seen_next;
                    if (64'(seen_next) >= want_reg)
                    begin
                        pct_reg <= (edge_val > rec_max_reg) ? rec_max_reg : edge_val;
                    end
                    else if (walk_reg == LAST_IDX)
                    begin
                        // Saturated buckets can leave the rank unreached.
                        pct_reg <= rec_max_reg;
                    end
                    else
                    begin
                        walk_reg <= walk_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        res_reg.latency_us      <= lat_ok_reg ? lat_reg : '0;
                        res_reg.feed_age_us     <= feed_age;
                        res_reg.percentile_us   <= pct_reg;
                        res_reg.signal_total    <= sig_cnt_reg;
                        res_reg.latency_count   <= rec_cnt_reg;
                        res_reg.latency_min_us  <= rec_min_reg;
                        res_reg.latency_max_us  <= rec_max_reg;
                        res_reg.latency_sum_us  <= rec_sum_reg;
                        res_reg.software_count  <= soft_cnt_reg;
                        res_reg.software_sum_ns <= soft_sum_reg;
                        res_reg.software_max_ns <= soft_max_reg;
                        valid_out_reg           <= lat_ok_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = res_reg;
    assign m_tuser[0] = valid_out_reg;

    // No event enters while the memories are still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!ring_busy && !hist_busy))
        else $error("event accepted during memory clear");

    // Ring completions only arrive while the sequencer waits for them.
    a_ring_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ring_done |-> (state_reg == ST_RING))
        else $error("ring completion outside ring wait");

    a_rank_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rank_done |-> (state_reg == ST_RANK))
        else $error("rank completion outside rank wait");

    // A recorded latency lies between the reported minimum and maximum.
    a_latency_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && valid_out_reg) |->
            ((res_reg.latency_us >= res_reg.latency_min_us)
             && (res_reg.latency_us <= res_reg.latency_max_us)))
        else $error("recorded latency outside min and max");

    // A percentile answer never exceeds the largest recorded latency.
    a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (res_reg.percentile_us <= res_reg.latency_max_us))
        else $error("percentile above maximum latency");

endmodule

// ===== tb/sv/latency_histogram_monitor_test.sv =====
// Self-checking testbench for the latency histogram monitor: directed table, random events, checker.
`timescale 1ns / 1ps

module latency_histogram_monitor_test;
    import lhm_pkg::*;

    localparam int NUM_BUCKETS   = 32;
    localparam int RING_SLOTS    = 256;
    localparam int NUM_FIELDS    = 11;
    localparam int RANDOM_EVENTS = 1600;
    localparam int DRAIN_POINT   = 800;      // the sender pauses here until all results are in
    localparam int HOLD_AFTER    = 600;      // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 120;      // covers the slowest percentile walk
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int MAX_PRINTED   = 50;

    // One stimulus row. When pinned is set, the latency, valid flag and percentile are
    // the values typed in the table rather than those of the predictor.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SEQ_W-1:0]  seq;
        time_t             now;
        time_t             sample;
        logic [FRAC_W-1:0] frac;
        logic              pinned;
        time_t             lat;
        logic              valid;
        time_t             pct;
    } event_row_t;

    typedef struct packed {
        logic    valid;
        result_t stats;
    } outcome_t;

    localparam time_t ALL_ONES = '1;

    // Directed events: empty histogram, empty and zero-time slots, ring wrap, a signal
    // from the future, latency extremes, sample extremes and percentile extremes.
    localparam int PLAN_LEN = 23;
    event_row_t plan [PLAN_LEN] = '{
        '{OP_PCTL,   32'd0,        64'd0,     64'd0,    17'd65536,  1'b1, 64'd0, 1'b0, 64'd0},
        '{OP_SIGNAL, 32'd5,        64'd100,   64'd0,    17'd0,      1'b1, 64'd0, 1'b0, 64'd0},
        '{OP_TICK,   32'd7,        64'd0,     64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SIGNAL, 32'd7,        64'd50,    64'd0,    17'd0,      1'b1, 64'd0, 1'b0, 64'd0},
        '{OP_TICK,   32'd1,        64'd1000,  64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SIGNAL, 32'd1,        64'd1000,  64'd0,    17'd0,      1'b1, 64'd0, 1'b1, 64'd0},
        '{OP_SIGNAL, 32'd257,      64'd1001,  64'd0,    17'd0,      1'b1, 64'd1, 1'b1, 64'd0},
        '{OP_SIGNAL, 32'd1,        64'd999,   64'd0,    17'd0,      1'b1, 64'd0, 1'b0, 64'd0},
        '{OP_TICK,   32'hFFFFFFFF, 64'd2000,  64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SIGNAL, 32'hFFFFFFFF, 64'd3023,  64'd0,    17'd0,      1'b1, 64'd1023, 1'b1, 64'd0},
        '{OP_TICK,   32'd2,        64'd1,     64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SIGNAL, 32'd2,        ALL_ONES,  64'd0,    17'd0,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'd0},
        '{OP_SAMPLE, 32'd0,        64'd5000,  64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SAMPLE, 32'd0,        64'd5001,  ALL_ONES, 17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SAMPLE, 32'd0,        64'd5002,  64'd12345, 17'd0,     1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_PCTL,   32'd0,        64'd5003,  64'd0,    17'd0,      1'b1, 64'd0, 1'b0, 64'd2},
        '{OP_PCTL,   32'd0,        64'd5004,  64'd0,    17'd65536,
          1'b1, 64'd0, 1'b0, 64'h1_0000_0000},
        '{OP_PCTL,   32'd0,        64'd5005,  64'd0,    17'h1FFFF,
          1'b1, 64'd0, 1'b0, 64'h1_0000_0000},
        '{OP_PCTL,   32'd0,        64'd5006,  64'd0,    17'd32768,  1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_TICK,   32'd9,        ALL_ONES,  64'd0,    17'd0,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_PCTL,   32'd0,        64'd0,     64'd0,    17'd1,      1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_TICK,   32'h80000000, 64'h8000_0000_0000_0000, 64'd0, 17'd0,
          1'b0, 64'd0, 1'b0, 64'd0},
        '{OP_SAMPLE, 32'd0,        64'd7,     64'h5555_5555_5555_5555, 17'd0,
          1'b0, 64'd0, 1'b0, 64'd0}
    };

    string field_name [NUM_FIELDS] = '{
        "latency_us", "feed_age_us", "percentile_us", "signal_total", "latency_count",
        "latency_min_us", "latency_max_us", "latency_sum_us", "software_count",
        "software_sum_ns", "software_max_ns"
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    // Predicted statistics of the block.
    time_t       tick_ring [RING_SLOTS];
    time_t       last_tick;
    time_t       sig_total;
    time_t       lat_recorded;
    time_t       lat_sum;
    time_t       lat_min;
    time_t       lat_max;
    logic [31:0] bucket_hits [NUM_BUCKETS];
    time_t       soft_samples;
    time_t       sw_sum;
    time_t       sw_max;

    outcome_t          pending_results [$];
    logic [SEQ_W-1:0]  recent_ticks [$];
    time_t             clock_us = 64'd10000;
    logic [SEQ_W-1:0]  next_seq = 32'd100;
    int                errors = 0;
    int                results_seen = 0;
    int                cycles = 0;
    bit                tx_burst = 1'b0;
    bit                rx_burst = 1'b0;
    bit                long_hold_done = 1'b0;

    latency_histogram_monitor #(
        .BUCKETS    (NUM_BUCKETS),
        .RING_DEPTH (RING_SLOTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("latency_histogram_monitor_test NOT OK");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (errors < MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic time_t rand64();
        return {$urandom, $urandom};
    endfunction

    // Latency-like value whose bit length is spread over the whole 64-bit range,
    // with short values more likely so that the low buckets fill as well.
    function automatic time_t rand_latency();
        int w;
        w = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 20) : $urandom_range(21, 64);
        return (w == 0) ? 64'd0 : (rand64() >> (64 - w));
    endfunction

    // Mostly short gaps, a few long ones, and bursts with no gap at all.
    function automatic int pick_gap(inout bit burst);
        int r;
        if ($urandom_range(0, 99) < 3)
            burst = !burst;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int bucket_index(input time_t value);
        int b;
        b = 0;
        while (value > 1 && b < NUM_BUCKETS - 1)
        begin
            value = value >> 1;
            b++;
        end
        return b;
    endfunction

    // Walks the histogram up to the requested rank and answers that bucket's upper edge, capped at the largest latency.
    function automatic time_t percentile_answer(input logic [FRAC_W-1:0] frac);
        logic [95:0] scaled;
        time_t       want;
        time_t       seen;
        time_t       bound;
        int          b;
        if (lat_recorded == 0)
            return '0;
        scaled = ({32'd0, lat_recorded} * {79'd0, frac}) + 96'd65470;
        scaled = scaled >> 16;
        want = (scaled > {32'd0, lat_recorded}) ? lat_recorded : scaled[63:0];
        if (want == 0)
            want = 1;
        seen = '0;
        for (b = 0; b < NUM_BUCKETS; b++)
        begin
            if (bucket_hits[b] != 0)
            begin
                seen += bucket_hits[b];
                if (seen >= want)
                begin
                    // An edge past the 64-bit range reads as all ones.
                    bound = (b + 1 < 64) ? (64'd1 << (b + 1)) : ALL_ONES;
                    return (bound > lat_max) ? lat_max : bound;
                end
            end
        end
        return lat_max;
    endfunction

    // Applies one accepted event to the predicted state and returns its result.
    function automatic outcome_t account_event(input event_row_t ev);
        outcome_t    res;
        time_t       stored;
        time_t       lat;
        int          b;
        int unsigned slot;
        res  = '0;
        slot = ev.seq % RING_SLOTS;
        case (ev.op)
            OP_TICK:
            begin
                tick_ring[slot] = ev.now;
                last_tick       = ev.now;
            end
            OP_SIGNAL:
            begin
                stored = tick_ring[slot];
                sig_total++;
                // An empty slot reads as zero; a tick later than the signal is ignored.
                if (stored != 0 && ev.now >= stored)
                begin
                    lat = ev.now - stored;
                    res.valid            = 1'b1;
                    res.stats.latency_us = lat;
                    lat_recorded++;
                    lat_sum += lat;
                    if (lat < lat_min)
                        lat_min = lat;
                    if (lat > lat_max)
                        lat_max = lat;
                    b = bucket_index(lat);
                    if (bucket_hits[b] != 32'hFFFF_FFFF)
                        bucket_hits[b]++;
                end
            end
            OP_SAMPLE:
            begin
                soft_samples++;
                sw_sum += ev.sample;
                if (ev.sample > sw_max)
                    sw_max = ev.sample;
            end
            OP_PCTL:
                res.stats.percentile_us = percentile_answer(ev.frac);
            default:
                ;
        endcase
        res.stats.feed_age_us     = (ev.now > last_tick) ? ev.now - last_tick : '0;
        res.stats.signal_total    = sig_total;
        res.stats.latency_count   = lat_recorded;
        res.stats.latency_min_us  = lat_min;
        res.stats.latency_max_us  = lat_max;
        res.stats.latency_sum_us  = lat_sum;
        res.stats.software_count  = soft_samples;
        res.stats.software_sum_ns = sw_sum;
        res.stats.software_max_ns = sw_max;
        return res;
    endfunction

    // Random events are mostly well formed: ticks on a rising time base and signals that
    // refer back to recent ticks. A share is noise with every field drawn at random.
    task automatic random_event(output event_row_t ev);
        int               r;
        logic [SEQ_W-1:0] s;
        time_t            base;
        ev = '{default: '0};
        r  = $urandom_range(0, 99);
        if (r < 30)
        begin
            if ($urandom_range(0, 19) == 0)
                next_seq = $urandom;
            ev.op  = OP_TICK;
            ev.seq = next_seq;
            next_seq++;
            clock_us += $urandom_range(1, 50);
            if ($urandom_range(0, 49) == 0)
                clock_us += rand64() >> $urandom_range(8, 40);
            ev.now = clock_us;
            recent_ticks.push_back(ev.seq);
            if (recent_ticks.size() > 24)
                void'(recent_ticks.pop_front());
        end
        else if (r < 65)
        begin
            if (recent_ticks.size() == 0 || $urandom_range(0, 19) == 0)
                s = $urandom;
            else
                s = recent_ticks[$urandom_range(0, recent_ticks.size() - 1)];
            base   = tick_ring[s % RING_SLOTS];
            ev.op  = OP_SIGNAL;
            ev.seq = s;
            // Now and then the signal claims a time earlier than its tick.
            if ($urandom_range(0, 9) == 0)
                ev.now = base - $urandom_range(1, 100);
            else
                ev.now = base + rand_latency();
        end
        else if (r < 77)
        begin
            ev.op     = OP_SAMPLE;
            ev.now    = clock_us + $urandom_range(0, 20);
            ev.sample = ($urandom_range(0, 3) == 0) ? rand64() : rand_latency();
        end
        else if (r < 87)
        begin
            ev.op  = OP_PCTL;
            ev.now = clock_us + $urandom_range(0, 20);
            case ($urandom_range(0, 9))
                0:       ev.frac = 17'd0;
                1:       ev.frac = 17'd65536;
                2:       ev.frac = FRAC_W'($urandom);
                default: ev.frac = FRAC_W'($urandom_range(0, 65536));
            endcase
        end
        else
        begin
            ev.op     = OP_W'($urandom);
            ev.seq    = $urandom;
            ev.now    = rand64();
            ev.sample = rand64();
            ev.frac   = FRAC_W'($urandom);
        end
    endtask

    // Offers one event after a gap and waits for its transfer; the expected result is
    // worked out at the edge that accepts it.
    task automatic send_event(input event_row_t ev, input int gap);
        outcome_t res;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = ev.op;
        s_tdata  = {7'd0, ev.frac, ev.sample, ev.now, ev.seq};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        res = account_event(ev);
        if (ev.pinned)
        begin
            res.stats.latency_us    = ev.lat;
            res.valid               = ev.valid;
            res.stats.percentile_us = ev.pct;
        end
        pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: every transfer on the output side is matched with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        outcome_t want;
        result_t  got;
        int       k;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (pending_results.size() == 0)
                report($sformatf("result %0d arrived with none expected", results_seen));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.valid)
                    report($sformatf("result %0d latency_valid: got %b want %b",
                                     results_seen, m_tuser[0], want.valid));
                for (k = 0; k < NUM_FIELDS; k++)
                begin
                    if (got[k*64 +: 64] !== want.stats[k*64 +: 64])
                        report($sformatf("result %0d %s: got %h want %h", results_seen,
                                         field_name[k], got[k*64 +: 64],
                                         want.stats[k*64 +: 64]));
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up into
    // its input while the sender keeps offering events.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = pick_gap(rx_burst);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        event_row_t ev;
        int         i;
        for (i = 0; i < RING_SLOTS; i++)
            tick_ring[i] = '0;
        for (i = 0; i < NUM_BUCKETS; i++)
            bucket_hits[i] = '0;
        last_tick    = '0;
        sig_total    = '0;
        lat_recorded = '0;
        lat_sum      = '0;
        lat_min      = '1;
        lat_max      = '0;
        soft_samples = '0;
        sw_sum       = '0;
        sw_max       = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < PLAN_LEN; i++)
            send_event(plan[i], pick_gap(tx_burst));
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();

        for (i = 0; i < RANDOM_EVENTS; i++)
        begin
            if (i == DRAIN_POINT)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                wait_drained();
            end
            random_event(ev);
            send_event(ev, pick_gap(tx_burst));
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        if (errors == 0)
            $display("latency_histogram_monitor_test OK");
        else
            $display("latency_histogram_monitor_test NOT OK");
        $finish;
    end

endmodule
